FILE: hw/rtl/lphs_pkg.sv
// package for the linear probing hash set unit
// holds shared types, sizes and codes; no dependencies

package lphs_pkg;

  localparam int unsigned SLOTS_DEF     = 256;
  localparam int unsigned KEY_BYTES_DEF = 20;
  localparam int unsigned FULL_KEY_W    = 160;
  localparam int unsigned COUNT_W       = 9;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_RESP
  } state_e;

  typedef logic [COUNT_W-1:0] count_t;

endpackage

FILE: hw/rtl/lphs_req_if.sv
// request channel of the hash set unit: valid, ready and one key command
// depends on nothing

interface lphs_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] key_word0;
  logic [63:0] key_word1;
  logic [31:0] key_word2;

  modport source (output valid, cmd, key_word0, key_word1, key_word2, input ready);
  modport sink   (input valid, cmd, key_word0, key_word1, key_word2, output ready);
endinterface

FILE: hw/rtl/lphs_rsp_if.sv
// result channel of the hash set unit: valid, ready and the lookup/insert outcome
// depends on nothing

interface lphs_rsp_if;
  logic       valid;
  logic       ready;
  logic       present;
  logic       inserted;
  logic       table_full;
  logic [8:0] entry_count;

  modport source (output valid, present, inserted, table_full, entry_count, input ready);
  modport sink   (input valid, present, inserted, table_full, entry_count, output ready);
endinterface

FILE: hw/rtl/lphs_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies

module lphs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lphs_cmp.sv
// key comparator shared by every probe step of the hash set unit
// no dependencies

module lphs_cmp #(
  parameter int unsigned KEY_W = 160
) (
  input  logic             slot_valid_i,
  input  logic [KEY_W-1:0] stored_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             match_o
);

  assign match_o = slot_valid_i && (stored_i == key_i);

endmodule

FILE: hw/rtl/lphs_ctrl.sv
// probe sequencer of the hash set unit: clearing pass, probe walk, count, result register
// depends on lphs_pkg, lphs_req_if and lphs_rsp_if

module lphs_ctrl #(
  parameter int unsigned SLOTS     = lphs_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BYTES = lphs_pkg::KEY_BYTES_DEF,
  localparam int unsigned SLOT_W   = $clog2(SLOTS),
  localparam int unsigned KEY_W    = KEY_BYTES * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lphs_req_if.sink          req_i,
  lphs_rsp_if.source        rsp_o,
  output logic              ram_we_o,
  output logic [SLOT_W-1:0] ram_waddr_o,
  output logic [KEY_W:0]    ram_wdata_o,
  output logic              ram_re_o,
  output logic [SLOT_W-1:0] ram_raddr_o,
  input  logic              slot_valid_i,
  input  logic              match_i,
  output logic [KEY_W-1:0]  key_o
);

  lphs_pkg::state_e state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] slot_nxt;
  lphs_pkg::count_t  count_q, count_d;
  logic present_q, present_d;
  logic inserted_q, inserted_d;
  logic full_q, full_d;
  lphs_pkg::cmd_e    cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [lphs_pkg::FULL_KEY_W-1:0] full_key;
  logic accept;
  logic is_insert;
  logic load_out;
  logic out_valid_q, out_valid_d;
  logic out_present_q, out_inserted_q, out_full_q;
  lphs_pkg::count_t out_count_q;

  assign full_key  = {req_i.key_word2, req_i.key_word1, req_i.key_word0};
  assign accept    = req_i.valid && req_i.ready;
  assign is_insert = (cmd_q == lphs_pkg::CMD_INSERT);
  assign slot_nxt  = slot_q + 1'b1;
  assign load_out  = (state_q == lphs_pkg::ST_RESP) && (!out_valid_q || rsp_o.ready);
  assign key_o     = key_q;

  // next state
  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    count_d    = count_q;
    present_d  = present_q;
    inserted_d = inserted_q;
    full_d     = full_q;
    unique case (state_q)
      lphs_pkg::ST_CLEAR: begin
        slot_d = slot_nxt;
        if (slot_q == '1) begin
          state_d = lphs_pkg::ST_IDLE;
        end
      end
      lphs_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          slot_d     = req_i.key_word0[SLOT_W-1:0];
          cnt_d      = '0;
          present_d  = 1'b0;
          inserted_d = 1'b0;
          full_d     = 1'b0;
          state_d    = lphs_pkg::ST_PROBE;
        end
      end
      lphs_pkg::ST_PROBE: begin
        state_d = lphs_pkg::ST_CHECK;
      end
      lphs_pkg::ST_CHECK: begin
        if (!slot_valid_i) begin
          inserted_d = is_insert;
          count_d    = count_q + lphs_pkg::count_t'(is_insert);
          state_d    = lphs_pkg::ST_RESP;
        end else if (match_i) begin
          present_d = 1'b1;
          state_d   = lphs_pkg::ST_RESP;
        end else if (cnt_q == '1) begin
          full_d  = is_insert;
          state_d = lphs_pkg::ST_RESP;
        end else begin
          slot_d = slot_nxt;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      lphs_pkg::ST_RESP: begin
        if (load_out) begin
          state_d = lphs_pkg::ST_IDLE;
        end
      end
      default: state_d = lphs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = slot_q;
    ram_wdata_o = {1'b1, key_q};
    ram_re_o    = 1'b0;
    ram_raddr_o = slot_q;
    unique case (state_q)
      lphs_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
      end
      lphs_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
      end
      lphs_pkg::ST_PROBE: begin
        ram_re_o = 1'b1;
      end
      lphs_pkg::ST_CHECK: begin
        // read the next slot ahead while this one is checked
        ram_re_o    = 1'b1;
        ram_raddr_o = slot_nxt;
        ram_we_o    = !slot_valid_i && is_insert;
      end
      lphs_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lphs_pkg::ST_CLEAR;
      slot_q      <= '0;
      cnt_q       <= '0;
      count_q     <= '0;
      present_q   <= 1'b0;
      inserted_q  <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      present_q   <= present_d;
      inserted_q  <= inserted_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= lphs_pkg::cmd_e'(req_i.cmd);
      key_q <= full_key[KEY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_present_q  <= present_q;
      out_inserted_q <= inserted_q;
      out_full_q     <= full_q;
      out_count_q    <= count_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.present     = out_present_q;
  assign rsp_o.inserted    = out_inserted_q;
  assign rsp_o.table_full  = out_full_q;
  assign rsp_o.entry_count = out_count_q;

endmodule

FILE: hw/rtl/linear_probe_hash_set_unit.sv
// Set of up to SLOTS keys in an open addressing table with linear probing. Each request is a
// lookup or an insert; the home slot is the low bits of the key's first four bytes, and the
// walk moves one slot per cycle through a single key/valid ram and one shared comparator.
// A request visits from 1 up to SLOTS slots, SLOTS when the table is full and the key absent.
// After reset a clearing pass writes every slot once, during which no request is taken.
// Requests are taken one at a time; a finished result waits in an output register while
// the next request is accepted. entry_count is the stored key count modulo 512.
// depends on lphs_pkg, lphs_req_if, lphs_rsp_if, lphs_ram, lphs_cmp and lphs_ctrl

module linear_probe_hash_set_unit #(
  parameter int unsigned SLOTS     = lphs_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BYTES = lphs_pkg::KEY_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lphs_req_if.sink   req_i,
  lphs_rsp_if.source rsp_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned KEY_W  = KEY_BYTES * 8;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [KEY_W:0]    ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [KEY_W:0]    ram_rdata;
  logic [KEY_W-1:0]  key;
  logic              match;

  lphs_ctrl #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .slot_valid_i (ram_rdata[KEY_W]),
    .match_i      (match),
    .key_o        (key)
  );

  lphs_ram #(
    .WIDTH (KEY_W + 1),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lphs_cmp #(
    .KEY_W (KEY_W)
  ) u_cmp (
    .slot_valid_i (ram_rdata[KEY_W]),
    .stored_i     (ram_rdata[KEY_W-1:0]),
    .key_i        (key),
    .match_o      (match)
  );

endmodule
